// ----- rtl/jpeg_frame_size_scanner_assert.svh -----
// Assertion macros used by the scanner top level.
`ifndef JPEG_FRAME_SIZE_SCANNER_ASSERT_SVH
`define JPEG_FRAME_SIZE_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JFSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define JFSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed (next cycle)");

`endif

// ----- rtl/jfss_pkg.sv -----
// Types, constants and helper functions of the JPEG frame size scanner.
package jfss_pkg;

    localparam int POSITION_BITS_DEF = 32;

    // Status codes of a result transaction
    localparam logic [2:0] ST_FOUND      = 3'd0;
    localparam logic [2:0] ST_BAD_SOI    = 3'd1;
    localparam logic [2:0] ST_BAD_JFIF   = 3'd2;
    localparam logic [2:0] ST_NOT_MARKER = 3'd3;
    localparam logic [2:0] ST_NO_DATA    = 3'd4;

    // Header layout (byte indexes from the start of the file)
    localparam int PREFIX_LEN     = 4;
    localparam int LEN_HI_POS     = 4;
    localparam int LEN_LO_POS     = 5;
    localparam int JFIF_FIRST_POS = 6;
    localparam int JFIF_LAST_POS  = 10;
    localparam int MIN_FIRST_LEN  = 6;
    localparam int FIRST_LEN_BASE = 4;
    localparam int MIN_SEG_LEN    = 2;

    // Offsets from the start-of-frame marker byte
    localparam int SOF_HEIGHT_HI = 5;
    localparam int SOF_HEIGHT_LO = 6;
    localparam int SOF_WIDTH_HI  = 7;
    localparam int SOF_WIDTH_LO  = 8;

    localparam logic [7:0] MARKER_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
    } t_out_item;

    // Parser to top: result of the current byte and the per-file outcome flag
    typedef struct packed {
        logic      produced;
        logic      sent;
        t_out_item item;
    } t_scan_res;

    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_SEEK = 6'b000010,
        PH_MARK = 6'b000100,
        PH_LENH = 6'b001000,
        PH_LENL = 6'b010000,
        PH_SOF  = 6'b100000
    } t_phase;

    // SOI + APP0 prefix
    function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hFF;
            2'd1:    b = 8'hD8;
            2'd2:    b = 8'hFF;
            default: b = 8'hE0;
        endcase
        return b;
    endfunction

    // Null-terminated JFIF identifier
    function automatic logic [7:0] jfif_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h4A;
            3'd1:    b = 8'h46;
            3'd2:    b = 8'h49;
            3'd3:    b = 8'h46;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Start-of-frame codes: C0..CF except DHT (C4), JPG (C8) and DAC (CC)
    function automatic logic is_sof(input logic [7:0] m);
        return (m >= 8'hC0) && (m <= 8'hCF) &&
               (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
    endfunction

endpackage

// ----- rtl/jfss_parser.sv -----
// Byte-at-a-time marker walker: header check, segment hopping, SOF decode.
module jfss_parser #(
    parameter int POSITION_BITS = jfss_pkg::POSITION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  jfss_pkg::t_in_item  i_item,
    output jfss_pkg::t_scan_res o_res
);
    import jfss_pkg::*;

    localparam int PW = POSITION_BITS;
    localparam logic [PW-1:0] POS_MAX = '1;

    t_phase        r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_nmp, n_nmp;
    logic [7:0]    r_hold, n_hold;
    logic [15:0]   r_height, n_height;
    logic          r_sent, n_sent;

    logic          can_parse;
    logic          produced;
    logic [2:0]    status;
    logic [15:0]   height;
    logic [15:0]   width;
    logic [7:0]    d;
    logic [15:0]   value16;
    logic [PW:0]   hdr_sum;
    logic [PW:0]   len_sum;
    logic [PW-1:0] k;
    logic [PW-1:0] jfif_off;

    always_comb begin
        d         = i_item.data_byte;
        value16   = {r_hold, d};
        can_parse = !r_sent && (r_pos != POS_MAX);
        hdr_sum   = (PW+1)'(r_height) + (PW+1)'(FIRST_LEN_BASE);
        len_sum   = {1'b0, r_pos} - (PW+1)'(1) + (PW+1)'(value16);
        k         = r_pos - r_nmp;
        jfif_off  = r_pos - PW'(JFIF_FIRST_POS);

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_nmp    = r_nmp;
        n_hold   = r_hold;
        n_height = r_height;
        n_sent   = r_sent;
        produced = 1'b0;
        status   = ST_FOUND;
        height   = '0;
        width    = '0;

        if (can_parse) begin
            case (r_phase)
                PH_HDR: begin
                    if (r_pos < PW'(PREFIX_LEN)) begin
                        if (d != prefix_byte(r_pos[1:0])) begin
                            produced = 1'b1;
                            status   = ST_BAD_SOI;
                        end
                    end else if (r_pos == PW'(LEN_HI_POS)) begin
                        n_hold = d;
                    end else if (r_pos == PW'(LEN_LO_POS)) begin
                        n_height = value16;
                    end else if (r_pos <= PW'(JFIF_LAST_POS)) begin
                        if (d != jfif_byte(jfif_off[2:0])) begin
                            produced = 1'b1;
                            status   = ST_BAD_JFIF;
                        end else if (r_pos == PW'(JFIF_LAST_POS)) begin
                            if (r_height <= 16'(MIN_FIRST_LEN)) begin
                                produced = 1'b1;
                                status   = ST_NOT_MARKER;
                            end else begin
                                n_nmp   = (hdr_sum > {1'b0, POS_MAX}) ? POS_MAX
                                                                       : hdr_sum[PW-1:0];
                                n_phase = PH_SEEK;
                            end
                        end
                    end
                end
                PH_SEEK: begin
                    if (r_pos == r_nmp) begin
                        if (d != MARKER_BYTE) begin
                            produced = 1'b1;
                            status   = ST_NOT_MARKER;
                        end else begin
                            n_phase = PH_MARK;
                        end
                    end
                end
                PH_MARK: begin
                    n_phase = is_sof(d) ? PH_SOF : PH_LENH;
                end
                PH_LENH: begin
                    n_hold  = d;
                    n_phase = PH_LENL;
                end
                PH_LENL: begin
                    if (value16 < 16'(MIN_SEG_LEN)) begin
                        produced = 1'b1;
                        status   = ST_NOT_MARKER;
                    end else begin
                        // current byte is marker+3; next marker sits at marker+2+len
                        n_nmp   = (len_sum > {1'b0, POS_MAX}) ? POS_MAX : len_sum[PW-1:0];
                        n_phase = PH_SEEK;
                    end
                end
                PH_SOF: begin
                    if (k == PW'(SOF_HEIGHT_HI) || k == PW'(SOF_WIDTH_HI)) begin
                        n_hold = d;
                    end else if (k == PW'(SOF_HEIGHT_LO)) begin
                        n_height = value16;
                    end else if (k == PW'(SOF_WIDTH_LO)) begin
                        produced = 1'b1;
                        status   = ST_FOUND;
                        height   = r_height;
                        width    = value16;
                    end
                end
                default: begin
                    n_phase = PH_HDR;
                end
            endcase
        end

        if (produced) begin
            n_sent = 1'b1;
        end
        if (r_pos != POS_MAX) begin
            n_pos = r_pos + PW'(1);
        end

        // final byte: report missing outcome, then rearm for the next file
        if (i_item.last_byte) begin
            if (!produced && !r_sent) begin
                produced = 1'b1;
                status   = ST_NO_DATA;
                height   = '0;
                width    = '0;
            end
            n_phase  = PH_HDR;
            n_pos    = '0;
            n_nmp    = '0;
            n_hold   = '0;
            n_height = '0;
            n_sent   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_pos    <= '0;
            r_nmp    <= '0;
            r_hold   <= '0;
            r_height <= '0;
            r_sent   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_nmp    <= n_nmp;
            r_hold   <= n_hold;
            r_height <= n_height;
            r_sent   <= n_sent;
        end
    end

    always_comb begin
        o_res.produced          = i_accept && produced;
        o_res.sent              = r_sent;
        o_res.item.status       = status;
        o_res.item.frame_height = height;
        o_res.item.frame_width  = width;
    end

endmodule

// ----- rtl/jpeg_frame_size_scanner.sv -----
// Top level of the JPEG frame size scanner: parser plus output register and skid stage.
//
// Feed a JPEG file one byte per input transaction, setting last_byte on the
// final byte. The block checks the SOI+APP0 prefix and the JFIF identifier,
// follows the segment lengths from marker to marker and stops at the first
// start-of-frame marker, returning exactly one result transaction per file:
// status 0 with height and width, or an error status (1 bad SOI/APP0,
// 2 bad JFIF, 3 marker byte not FF or segment length too short, 4 file
// ended before an outcome). The result leaves as soon as the deciding byte
// is taken; later bytes of the same file are swallowed and the block rearms
// after the final byte, so files may follow each other back to back with no
// gap. The parse is a single pass of compares and adds from the input port
// into the result register, so one byte is accepted per clock while o_stall
// is low. A result is registered into the output register, or into the skid
// entry while the output register is held. The output has a register plus
// one skid entry; o_stall rises only while the skid entry is occupied. Byte
// positions are POSITION_BITS wide and saturate, so bytes from position
// 2^POSITION_BITS-1 on are not parsed and such a file ends with status 4.
`include "jpeg_frame_size_scanner_assert.svh"

module jpeg_frame_size_scanner #(
    parameter int POSITION_BITS = jfss_pkg::POSITION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  jfss_pkg::t_in_item i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output jfss_pkg::t_out_item o_data
);
    import jfss_pkg::*;

    logic      accept;
    logic      take;
    t_scan_res res;

    // Output register and skid entry
    logic      r_out_v;
    t_out_item r_out;
    logic      r_skid_v;
    t_out_item r_skid;

    // Accept a byte whenever the skid entry is free
    assign o_stall = r_skid_v;
    assign accept  = i_valid && !o_stall;
    assign take    = r_out_v && !i_stall;

    jfss_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_res    (res)
    );

    // Valid flags: drain the skid into the output register first, park a
    // new result in the skid only when the output register cannot move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (res.produced) begin
            if (r_out_v && !take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (res.produced) begin
            if (r_out_v && !take) begin
                r_skid <= res.item;
            end else begin
                r_out <= res.item;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // The skid entry only fills behind a held output register
    `JFSS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    // At most one result per file
    `JFSS_ASSERT_NOW(a_one_result, i_clk, i_rst_n, accept && res.sent, !res.produced)
    // Dimensions are zero on every error status
    `JFSS_ASSERT_NOW(a_err_zero, i_clk, i_rst_n,
        res.produced && (res.item.status != ST_FOUND),
        (res.item.frame_height == 16'd0) && (res.item.frame_width == 16'd0))
    // The final byte rearms the scanner
    `JFSS_ASSERT_NEXT(a_rearm, i_clk, i_rst_n, accept && i_data.last_byte, !res.sent)

endmodule
